@@ design/rsx_pkg.sv @@
// Shared types and constants for the RISC subset execute unit.
`default_nettype none
package rsx_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned XLEN          = 32;
  localparam int unsigned REG_IDX_W     = 5;
  localparam int unsigned IN_TDATA_W    = 56;
  localparam int unsigned OUT_TDATA_W   = 208;

  typedef enum logic [4:0] {
    ACT_ADD     = 5'd0,
    ACT_ADDI    = 5'd1,
    ACT_AND     = 5'd2,
    ACT_BEQ     = 5'd3,
    ACT_BGTZ    = 5'd4,
    ACT_BLEZ    = 5'd5,
    ACT_BNE     = 5'd6,
    ACT_DIV     = 5'd7,
    ACT_J       = 5'd8,
    ACT_JAL     = 5'd9,
    ACT_JR      = 5'd10,
    ACT_LUI     = 5'd11,
    ACT_LW      = 5'd12,
    ACT_MFHI    = 5'd13,
    ACT_MFLO    = 5'd14,
    ACT_MULT    = 5'd15,
    ACT_NOP     = 5'd16,
    ACT_OR      = 5'd17,
    ACT_ROTR    = 5'd18,
    ACT_SLL     = 5'd19,
    ACT_SLT     = 5'd20,
    ACT_SRL     = 5'd21,
    ACT_SUB     = 5'd22,
    ACT_SW      = 5'd23,
    ACT_SYSCALL = 5'd24,
    ACT_XOR     = 5'd25
  } act_t;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_DIV0  = 2'd1;
  localparam status_t STAT_UNSUP = 2'd2;

  // decoded word handed from front to back
  typedef struct packed {
    act_t                 op;
    logic                 unsup;
    logic                 is_mem;
    logic [REG_IDX_W-1:0] reg_a;
    logic [REG_IDX_W-1:0] reg_b;
    logic [REG_IDX_W-1:0] reg_c;
    logic [XLEN-1:0]      imm;
  } dec_t;

  typedef enum logic [3:0] {
    BE_CLR,
    BE_IDLE,
    BE_RDAB,
    BE_RDC,
    BE_OPS,
    BE_DISP,
    BE_MOD,
    BE_MOD2,
    BE_MOD3,
    BE_MEMRD,
    BE_DIV,
    BE_EXEC
  } be_st_t;

endpackage
`default_nettype wire

@@ design/risc_subset_execute_unit_core.sv @@
// Top level of the RISC subset execute unit.
//
//  channel | direction | tdata layout (lsb first)
//  in      | slave     | action[4:0] reg_a[9:5] reg_b[14:10] reg_c[19:15] imm[51:20], pad
//  out     | master    | next_pc, reg_write, reg_index, reg_value, mem_write,
//          |           | mem_address, mem_value, hi_value, lo_value, status, pad
//
// Steps per word for most operations: queue pop, three register file read
// stages, dispatch, execute/commit; lw and sw add a memory read step, plus
// the states BE_MOD, BE_MOD2 and BE_MOD3 when MEM_WORDS is not a power of two
// (address modulo by a reciprocal multiply and one correcting subtract). div
// with a nonzero divisor waits in BE_DIV on the one-bit-per-cycle divider.
// Reset: a clearing pass zeroes every word of the data memory; in_tready
// stays low throughout. The register file clears at once through valid bits.
// Stalls: the two-word queue lets the front keep taking words while the back
// end works or waits on out_tready; the result register holds until taken.
`default_nettype none
module risc_subset_execute_unit_core #(
  parameter int unsigned MEM_WORDS = rsx_pkg::MEM_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // action, reg_a, reg_b, reg_c, imm, zero pad
  input  wire logic [rsx_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // next_pc, reg_write, reg_index, reg_value, mem_write, mem_address,
  // mem_value, hi_value, lo_value, status, zero pad
  output logic [rsx_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  logic          be_busy, q_vld, q_pop;
  rsx_pkg::dec_t q_data;

  rsx_fe u_fe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .be_busy   (be_busy),
    .q_vld     (q_vld),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  rsx_be #(.MEM_WORDS(MEM_WORDS)) u_be (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .be_busy    (be_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ design/rsx_fe.sv @@
// Front end: accepts input words, classifies them and queues them for the back end.
`default_nettype none
module rsx_fe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rsx_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          be_busy,
  output logic                               q_vld,
  output rsx_pkg::dec_t                      q_data,
  input  wire logic                          q_pop
);

  rsx_pkg::dec_t fifo_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;
  rsx_pkg::dec_t dec;
  logic [4:0]    code;

  assign code = in_tdata[4:0];

  always_comb begin
    dec        = '0;
    dec.reg_a  = in_tdata[9:5];
    dec.reg_b  = in_tdata[14:10];
    dec.reg_c  = in_tdata[19:15];
    dec.imm    = in_tdata[51:20];
    dec.op     = rsx_pkg::ACT_NOP;
    dec.unsup  = 1'b0;
    dec.is_mem = 1'b0;
    unique case (code)
      rsx_pkg::ACT_JAL, rsx_pkg::ACT_SYSCALL: dec.unsup = 1'b1;
      rsx_pkg::ACT_LW, rsx_pkg::ACT_SW: begin
        dec.op     = rsx_pkg::act_t'(code);
        dec.is_mem = 1'b1;
      end
      default: begin
        if (code > rsx_pkg::ACT_XOR) dec.unsup = 1'b1;
        else dec.op = rsx_pkg::act_t'(code);
      end
    endcase
  end

  assign in_tready = !be_busy && (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_vld     = (cnt_r != 2'd0);
  assign q_data    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

@@ design/rsx_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
`default_nettype none
module rsx_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [rsx_pkg::XLEN-1:0] num,
  input  wire logic [rsx_pkg::XLEN-1:0] den,
  output logic                         done,
  output logic [rsx_pkg::XLEN-1:0]     quo,
  output logic [rsx_pkg::XLEN-1:0]     rem
);

  logic [rsx_pkg::XLEN-1:0] rem_r, quo_r, den_r;
  logic [4:0]               cnt_r;
  logic                     busy_r, done_r;
  logic [rsx_pkg::XLEN:0]   shl, diff;

  assign shl  = {rem_r, quo_r[rsx_pkg::XLEN-1]};
  assign diff = shl - {1'b0, den_r};
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (!diff[rsx_pkg::XLEN]) begin
        rem_r <= diff[rsx_pkg::XLEN-1:0];
        quo_r <= {quo_r[rsx_pkg::XLEN-2:0], 1'b1};
      end else begin
        rem_r <= shl[rsx_pkg::XLEN-1:0];
        quo_r <= {quo_r[rsx_pkg::XLEN-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) busy_r <= 1'b1;
      else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/rsx_be.sv @@
// Back end: register file, data memory, sequencer and result register.
`default_nettype none
module rsx_be #(
  parameter int unsigned MEM_WORDS = rsx_pkg::MEM_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_vld,
  input  rsx_pkg::dec_t                       q_data,
  output logic                                q_pop,
  output logic                                be_busy,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [rsx_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int unsigned AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam bit          IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam logic [AW-1:0] LAST  = AW'(MEM_WORDS - 1);
  localparam int unsigned X       = rsx_pkg::XLEN;
  localparam logic [X-1:0] NW     = X'(MEM_WORDS);
  // floor(2^32 / MEM_WORDS): quotient estimate is exact or one short
  localparam logic [X-1:0] RECIP  = X'(64'h1_0000_0000 / 64'(MEM_WORDS));

  rsx_pkg::be_st_t st_r, st_nxt;
  rsx_pkg::dec_t   ins_r;

  logic [X-1:0] rf [32];
  logic [31:0]  vld_r;
  logic [4:0]   ra0, ra1;
  logic [X-1:0] rd0_r, rd1_r, v0, v1;
  logic         ok0_r, ok1_r;

  logic [X-1:0] mem [MEM_WORDS];
  logic [X-1:0] mem_rd_r;
  logic [AW-1:0] idx_r, clr_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [X-1:0]  mem_wd;

  logic [X-1:0] va_r, vb_r, vc_r, addr_r, pc_r, hi_r, lo_r;
  logic         nneg_r, qneg_r;

  // address modulo for non power-of-two memories
  logic [2*X-1:0] mprod;
  logic [X-1:0]   qe_r, qn, rm_r;

  logic         div_start, div_done;
  logic [X-1:0] div_num, div_den, div_quo, div_rem;

  logic         out_free, commit;
  logic [rsx_pkg::OUT_TDATA_W-1:0] out_r;
  logic         out_vld_r;

  // execute results
  logic            wr;
  logic [X-1:0]    wval, pc_n, hi_n, lo_n, maddr, mval;
  logic            mw;
  rsx_pkg::status_t stat;
  logic [2*X-1:0]  rot;
  logic [X-1:0]    prod;

  rsx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // register file: two registered read ports, one write port
  always_comb begin
    ra0 = ins_r.reg_a;
    ra1 = ins_r.reg_b;
    if (st_r == rsx_pkg::BE_RDC) ra0 = ins_r.reg_c;
  end

  assign v0 = ok0_r ? rd0_r : '0;
  assign v1 = ok1_r ? rd1_r : '0;

  always_ff @(posedge clk) begin
    rd0_r <= rf[ra0];
    rd1_r <= rf[ra1];
    if (commit && wr) rf[ins_r.reg_a] <= wval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok0_r <= 1'b0;
      ok1_r <= 1'b0;
    end else begin
      ok0_r <= vld_r[ra0] && (ra0 != 5'd0);
      ok1_r <= vld_r[ra1] && (ra1 != 5'd0);
      if (commit && wr) vld_r[ins_r.reg_a] <= 1'b1;
    end
  end

  // data memory
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = va_r;
    if (st_r == rsx_pkg::BE_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (commit && mw) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[idx_r];
  end

  assign mprod = addr_r * RECIP;
  assign qn    = qe_r * NW;

  // execute
  assign rot  = {vb_r, vb_r} >> ins_r.imm[4:0];
  assign prod = va_r * vb_r;

  always_comb begin
    wr    = 1'b0;
    wval  = '0;
    mw    = 1'b0;
    maddr = '0;
    mval  = '0;
    pc_n  = pc_r;
    hi_n  = hi_r;
    lo_n  = lo_r;
    stat  = rsx_pkg::STAT_OK;
    if (ins_r.unsup) begin
      stat = rsx_pkg::STAT_UNSUP;
    end else begin
      unique case (ins_r.op)
        rsx_pkg::ACT_ADD:  begin wr = 1'b1; wval = vb_r + vc_r; end
        rsx_pkg::ACT_ADDI: begin wr = 1'b1; wval = vb_r + ins_r.imm; end
        rsx_pkg::ACT_AND:  begin wr = 1'b1; wval = vb_r & vc_r; end
        rsx_pkg::ACT_OR:   begin wr = 1'b1; wval = vb_r | vc_r; end
        rsx_pkg::ACT_XOR:  begin wr = 1'b1; wval = vb_r ^ vc_r; end
        rsx_pkg::ACT_SUB:  begin wr = 1'b1; wval = vb_r - vc_r; end
        rsx_pkg::ACT_SLT: begin
          wr   = 1'b1;
          wval = X'($signed(vb_r) < $signed(vc_r));
        end
        rsx_pkg::ACT_SLL:  begin wr = 1'b1; wval = vb_r << ins_r.imm[4:0]; end
        rsx_pkg::ACT_SRL:  begin wr = 1'b1; wval = vb_r >> ins_r.imm[4:0]; end
        rsx_pkg::ACT_ROTR: begin wr = 1'b1; wval = rot[X-1:0]; end
        rsx_pkg::ACT_LUI:  begin wr = 1'b1; wval = {ins_r.imm[15:0], 16'h0000}; end
        rsx_pkg::ACT_LW:   begin wr = 1'b1; wval = mem_rd_r; end
        rsx_pkg::ACT_MFHI: begin wr = 1'b1; wval = hi_r; end
        rsx_pkg::ACT_MFLO: begin wr = 1'b1; wval = lo_r; end
        rsx_pkg::ACT_SW: begin
          mw    = 1'b1;
          maddr = addr_r;
          mval  = va_r;
        end
        rsx_pkg::ACT_BEQ:  if (va_r == vb_r) pc_n = pc_r + ins_r.imm;
        rsx_pkg::ACT_BNE:  if (va_r != vb_r) pc_n = pc_r + ins_r.imm;
        rsx_pkg::ACT_BGTZ: if ($signed(va_r) > 0) pc_n = pc_r + ins_r.imm;
        rsx_pkg::ACT_BLEZ: if ($signed(va_r) <= 0) pc_n = pc_r + ins_r.imm;
        rsx_pkg::ACT_J:    pc_n = pc_r + ins_r.imm;
        rsx_pkg::ACT_JR:   pc_n = va_r;
        rsx_pkg::ACT_MULT: lo_n = prod;
        rsx_pkg::ACT_DIV: begin
          if (vb_r == '0) begin
            stat = rsx_pkg::STAT_DIV0;
          end else begin
            lo_n = qneg_r ? (~div_quo + 1'b1) : div_quo;
            hi_n = nneg_r ? (~div_rem + 1'b1) : div_rem;
          end
        end
        default: ;
      endcase
    end
    if (ins_r.reg_a == 5'd0) wr = 1'b0;
    if (!wr) wval = '0;
  end

  // sequencer
  assign out_free = !out_vld_r || out_tready;
  assign be_busy  = (st_r == rsx_pkg::BE_CLR);

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    div_num   = va_r[X-1] ? (~va_r + 1'b1) : va_r;
    div_den   = vb_r[X-1] ? (~vb_r + 1'b1) : vb_r;
    unique case (st_r)
      rsx_pkg::BE_CLR:  if (clr_r == LAST) st_nxt = rsx_pkg::BE_IDLE;
      rsx_pkg::BE_IDLE: begin
        if (q_vld) begin
          q_pop  = 1'b1;
          st_nxt = rsx_pkg::BE_RDAB;
        end
      end
      rsx_pkg::BE_RDAB: st_nxt = rsx_pkg::BE_RDC;
      rsx_pkg::BE_RDC:  st_nxt = rsx_pkg::BE_OPS;
      rsx_pkg::BE_OPS:  st_nxt = rsx_pkg::BE_DISP;
      rsx_pkg::BE_DISP: begin
        if (ins_r.is_mem) begin
          if (IS_POW2) st_nxt = rsx_pkg::BE_MEMRD;
          else st_nxt = rsx_pkg::BE_MOD;
        end else if (!ins_r.unsup && ins_r.op == rsx_pkg::ACT_DIV && vb_r != '0) begin
          div_start = 1'b1;
          st_nxt    = rsx_pkg::BE_DIV;
        end else begin
          st_nxt = rsx_pkg::BE_EXEC;
        end
      end
      rsx_pkg::BE_MOD:   st_nxt = rsx_pkg::BE_MOD2;
      rsx_pkg::BE_MOD2:  st_nxt = rsx_pkg::BE_MOD3;
      rsx_pkg::BE_MOD3:  st_nxt = rsx_pkg::BE_MEMRD;
      rsx_pkg::BE_MEMRD: st_nxt = rsx_pkg::BE_EXEC;
      rsx_pkg::BE_DIV:   if (div_done) st_nxt = rsx_pkg::BE_EXEC;
      rsx_pkg::BE_EXEC: begin
        if (out_free) begin
          commit = 1'b1;
          st_nxt = rsx_pkg::BE_IDLE;
        end
      end
      default: st_nxt = rsx_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= rsx_pkg::BE_CLR;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == rsx_pkg::BE_CLR) clr_r <= clr_r + 1'b1;
      if (commit) begin
        out_vld_r <= 1'b1;
        pc_r      <= pc_n;
        hi_r      <= hi_n;
        lo_r      <= lo_n;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ins_r <= q_data;
    if (st_r == rsx_pkg::BE_RDC) va_r <= v0;
    if (st_r == rsx_pkg::BE_OPS) begin
      vb_r   <= v1;
      vc_r   <= v0;
      addr_r <= v0 + ins_r.imm;
    end
    if (st_r == rsx_pkg::BE_DISP) begin
      idx_r  <= addr_r[AW-1:0];
      nneg_r <= va_r[X-1];
      qneg_r <= va_r[X-1] ^ vb_r[X-1];
    end
    // quotient estimate, remainder below 2*MEM_WORDS, one correcting subtract
    if (st_r == rsx_pkg::BE_MOD)  qe_r <= mprod[2*X-1:X];
    if (st_r == rsx_pkg::BE_MOD2) rm_r <= addr_r - qn;
    if (st_r == rsx_pkg::BE_MOD3) idx_r <= (rm_r >= NW) ? AW'(rm_r - NW) : rm_r[AW-1:0];
    if (commit) begin
      out_r <= {7'd0, stat, lo_n, hi_n, mval, maddr, mw, wval,
                (wr ? ins_r.reg_a : 5'd0), wr, pc_n};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

@@ design/rsx_chk.sv @@
// Port-level checker for the execute unit, bound to the top level.
`default_nettype none
module rsx_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [rsx_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_rst_clr: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during memory clear");

  a_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[37:33] != 5'd0)
    else $error("write reported to register zero");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[200:199] != rsx_pkg::STAT_OK |-> !out_tdata[32] && !out_tdata[70])
    else $error("failed word has side effects");

endmodule

bind risc_subset_execute_unit_core rsx_chk u_rsx_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
